// ===== rtl/two_key_lookup_table_macros.svh =====
// Assertion macros shared by the two key lookup table RTL.
`ifndef TWO_KEY_LOOKUP_TABLE_MACROS_SVH
`define TWO_KEY_LOOKUP_TABLE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TKLT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TKLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tklt_pkg.sv =====
// Types and constants for the two key lookup table.
package tklt_pkg;

  localparam int KEY_W    = 32;
  localparam int COL_W    = 11;
  localparam int CELL_W   = 16;
  localparam int FOUND_W  = 15;
  localparam int STATUS_W = 2;
  localparam int OP_W     = 2;

  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_MAX_COLUMN = 1023;

  localparam logic [CELL_W-1:0] EMPTY_CELL = '1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_LOOKUP = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_MISS       = 2'd1,
    STAT_BAD_COLUMN = 2'd2,
    STAT_FULL       = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_WRITE,
    S_READ,
    S_RDWAIT,
    S_DONE
  } state_t;

endpackage

// ===== rtl/two_key_lookup_table.sv =====
// Two key lookup table: sequencer, row key scan, row allocation and cell memory.
//
// Usage:
//   Input channel in_*: one beat carries an opcode (clear, insert, lookup), a
//   32-bit row key, an 11-bit column and a 16-bit cell value. Output channel
//   out_*: every input beat yields exactly one result beat with a status
//   (ok, miss, bad column, table full) and a 15-bit found value.
//   Both channels are valid/ready; a beat moves when valid and ready are high.
// Sequence per item:
//   clear, unused opcode, bad column: straight from idle to the done state.
//   lookup: key scan, one row per cycle, then a registered cell read;
//   insert to an existing row: key scan, then the cell write.
//   insert that allocates a row: key scan, then a sweep of the new row's
//   cells to the empty marker through the single cell write port, then the write.
// Throughput: one item at a time; the scan reads one row key per cycle
//   through the row key memory read port.
// Reset: all rows become free at once (in-use flags are flops); key and cell
//   memories are not cleared, so no sweep follows reset.
// Stall: the result sits in an output register; a new beat is taken while it
//   waits, and the next result holds in the sequencer until the register frees.
`include "two_key_lookup_table_macros.svh"

module two_key_lookup_table
  import tklt_pkg::*;
#(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLUMN = DEF_MAX_COLUMN
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OP_W-1:0]            in_opcode,
  input  logic signed [KEY_W-1:0]    in_row_key,
  input  logic [COL_W-1:0]           in_column,
  input  logic signed [CELL_W-1:0]   in_cell_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic [FOUND_W-1:0]         out_found_value
);

  localparam int ROW_CELLS = MAX_COLUMN + 1;
  localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ROW_CW    = $clog2(MAX_ROWS + 1);
  localparam int CELL_AW   = $clog2(MAX_ROWS * ROW_CELLS);

  // Sequencer and control state
  state_t               state_r, state_nxt;
  logic [MAX_ROWS-1:0]  in_use_r, in_use_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 cmp_vld_r, cmp_vld_nxt;
  logic                 free_vld_r, free_vld_nxt;

  // Item and working registers
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [CELL_W-1:0]    val_r, val_nxt;
  logic [ROW_CW-1:0]    scan_cnt_r, scan_cnt_nxt;
  logic [ROW_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic [ROW_W-1:0]     free_idx_r, free_idx_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [COL_W-1:0]     fill_cnt_r, fill_cnt_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [FOUND_W-1:0]   res_value_r, res_value_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [FOUND_W-1:0]   out_found_r, out_found_nxt;

  // Memories and their registered read data
  logic [KEY_W-1:0]     key_mem [MAX_ROWS];
  logic [CELL_W-1:0]    cell_mem [MAX_ROWS * ROW_CELLS];
  logic [KEY_W-1:0]     key_rd_r;
  logic [CELL_W-1:0]    cell_rd_r;

  // Datapath nets
  logic [ROW_W-1:0]     scan_idx;
  logic                 issue_en;
  logic                 hit;
  logic                 cmp_free;
  logic                 scan_end;
  logic                 free_any;
  logic [ROW_W-1:0]     free_sel;
  logic                 key_we;
  logic                 cell_we;
  logic [CELL_AW-1:0]   cell_base;
  logic [CELL_AW-1:0]   cell_addr;
  logic [CELL_W-1:0]    cell_wdata;

  assign scan_idx  = scan_cnt_r[ROW_W-1:0];
  assign issue_en  = (scan_cnt_r < ROW_CW'(MAX_ROWS));
  // Shared compare unit: one stored key against the item key per cycle
  assign hit       = cmp_vld_r && in_use_r[cmp_idx_r] && (key_rd_r == key_r);
  assign cmp_free  = cmp_vld_r && !in_use_r[cmp_idx_r];
  assign scan_end  = cmp_vld_r && (cmp_idx_r == ROW_W'(MAX_ROWS - 1));
  // Lowest free row: an earlier one already seen wins over the current one
  assign free_any  = free_vld_r || cmp_free;
  assign free_sel  = free_vld_r ? free_idx_r : cmp_idx_r;
  assign cell_base = CELL_AW'(int'(row_r) * ROW_CELLS);

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_found_r;

  always_comb begin
    state_nxt      = state_r;
    in_use_nxt     = in_use_r;
    out_valid_nxt  = out_valid_r;
    cmp_vld_nxt    = cmp_vld_r;
    free_vld_nxt   = free_vld_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    col_nxt        = col_r;
    val_nxt        = val_r;
    scan_cnt_nxt   = scan_cnt_r;
    cmp_idx_nxt    = cmp_idx_r;
    free_idx_nxt   = free_idx_r;
    row_nxt        = row_r;
    fill_cnt_nxt   = fill_cnt_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    key_we         = 1'b0;
    cell_we        = 1'b0;
    cell_wdata     = val_r;
    cell_addr      = cell_base + CELL_AW'(col_r);

    // Drop the output beat once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt        = in_opcode;
          key_nxt       = in_row_key;
          col_nxt       = in_column;
          val_nxt       = in_cell_value;
          scan_cnt_nxt  = '0;
          cmp_vld_nxt   = 1'b0;
          free_vld_nxt  = 1'b0;
          res_value_nxt = '0;
          state_nxt     = S_DONE;
          case (in_opcode)
            OP_CLEAR: begin
              in_use_nxt     = '0;
              res_status_nxt = STAT_OK;
            end
            OP_INSERT, OP_LOOKUP: begin
              if (in_column > COL_W'(MAX_COLUMN)) begin
                res_status_nxt = STAT_BAD_COLUMN;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              res_status_nxt = STAT_MISS;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue one key read per cycle; compare the previous one
        cmp_vld_nxt = issue_en;
        cmp_idx_nxt = scan_idx;
        if (issue_en) begin
          scan_cnt_nxt = scan_cnt_r + ROW_CW'(1);
        end
        if (cmp_free && !free_vld_r) begin
          free_vld_nxt = 1'b1;
          free_idx_nxt = cmp_idx_r;
        end
        if (hit) begin
          row_nxt     = cmp_idx_r;
          cmp_vld_nxt = 1'b0;
          state_nxt   = (op_r == OP_LOOKUP) ? S_READ : S_WRITE;
        end else if (scan_end) begin
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_DONE;
          if (op_r == OP_LOOKUP) begin
            res_status_nxt = STAT_MISS;
          end else if (free_any) begin
            // Allocate the row, then sweep its cells to empty
            in_use_nxt[free_sel] = 1'b1;
            key_we               = 1'b1;
            row_nxt              = free_sel;
            fill_cnt_nxt         = '0;
            state_nxt            = S_FILL;
          end else begin
            res_status_nxt = STAT_FULL;
          end
        end
      end

      S_FILL: begin
        cell_we    = 1'b1;
        cell_wdata = EMPTY_CELL;
        cell_addr  = cell_base + CELL_AW'(fill_cnt_r);
        if (fill_cnt_r == COL_W'(MAX_COLUMN)) begin
          state_nxt = S_WRITE;
        end else begin
          fill_cnt_nxt = fill_cnt_r + COL_W'(1);
        end
      end

      S_WRITE: begin
        cell_we        = 1'b1;
        res_status_nxt = STAT_OK;
        state_nxt      = S_DONE;
      end

      S_READ: begin
        state_nxt = S_RDWAIT;
      end

      S_RDWAIT: begin
        // A negative cell is empty
        if (cell_rd_r[CELL_W-1]) begin
          res_status_nxt = STAT_MISS;
        end else begin
          res_status_nxt = STAT_OK;
          res_value_nxt  = cell_rd_r[FOUND_W-1:0];
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // Hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_value_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      free_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_use_r    <= in_use_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      free_vld_r  <= free_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    col_r        <= col_nxt;
    val_r        <= val_nxt;
    scan_cnt_r   <= scan_cnt_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    row_r        <= row_nxt;
    fill_cnt_r   <= fill_cnt_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
  end

  // Row key memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[free_sel] <= key_r;
    end
    key_rd_r <= key_mem[scan_idx];
  end

  // Cell memory: one port, registered read
  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_addr] <= cell_wdata;
    end
    cell_rd_r <= cell_mem[cell_addr];
  end

  `TKLT_ASSERT_NOW(a_out_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r == S_DONE), "output beat not loaded from done state")
  `TKLT_ASSERT_NOW(a_fill_row_in_use, clk, rst_n, state_r == S_FILL, in_use_r[row_r], "filling a row that is not allocated")
  `TKLT_ASSERT_NOW(a_found_only_ok, clk, rst_n, out_valid_r && (out_found_r != '0), out_status_r == STAT_OK, "found value without ok status")
  `TKLT_ASSERT_NEXT(a_clear_frees_rows, clk, rst_n, in_valid && in_ready && (in_opcode == OP_CLEAR), in_use_r == '0, "rows still in use after clear")

endmodule

// ===== verif/two_key_lookup_table_tb.sv =====
// Self-checking testbench for the two key lookup table: directed, fill, stall, random.
`timescale 1ns / 100ps

module two_key_lookup_table_tb;
  import tklt_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int ROWS        = DEF_MAX_ROWS;
  localparam int LAST_COL    = DEF_MAX_COLUMN;
  // Opcode 3 has no operation behind it; the block answers it with a miss.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_BEATS  = 1560;
  localparam int IDLE_PERCENT  = 29;
  localparam int HOLD_CYCLES   = 1500;
  // Worst single item: key scan, row sweep on allocation and the cell access.
  localparam int SETTLE_CYCLES = ROWS + LAST_COL + 32;
  localparam int CYCLE_LIMIT   = 10_000_000;
  localparam int KEY_POOL      = 8;
  localparam int COL_POOL      = 6;

  typedef struct packed {
    status_t            status;
    logic [FOUND_W-1:0] found;
  } lookup_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [OP_W-1:0]            in_opcode;
  logic signed [KEY_W-1:0]    in_row_key;
  logic [COL_W-1:0]           in_column;
  logic signed [CELL_W-1:0]   in_cell_value;
  logic                       out_valid;
  logic                       out_ready;
  logic [STATUS_W-1:0]        out_status;
  logic [FOUND_W-1:0]         out_found_value;

  // Shadow copy of the table: row keys, in-use flags and cell store.
  logic [KEY_W-1:0]  shadow_key [ROWS];
  bit                shadow_taken [ROWS];
  logic [CELL_W-1:0] shadow_cell [ROWS][LAST_COL+1];

  lookup_result_t   awaited_results[$];
  int               fail_count  = 0;
  int               cycle_count = 0;
  bit               calm         = 1'b0;
  bit               hold_request = 1'b0;

  logic [KEY_W-1:0] key_pool [KEY_POOL];
  logic [COL_W-1:0] col_pool [COL_POOL];

  two_key_lookup_table #(
    .MAX_ROWS   (ROWS),
    .MAX_COLUMN (LAST_COL)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_row_key      (in_row_key),
    .in_column       (in_column),
    .in_cell_value   (in_cell_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found_value (out_found_value)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  // Apply one accepted beat to the shadow table and return the answer it earns.
  function automatic lookup_result_t table_answer(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                                  logic [COL_W-1:0] col,
                                                  logic [CELL_W-1:0] val);
    lookup_result_t res;
    int row;
    res.status = STAT_OK;
    res.found  = '0;
    row = -1;
    case (op)
      OP_CLEAR: begin
        foreach (shadow_taken[r]) shadow_taken[r] = 1'b0;
      end
      OP_INSERT, OP_LOOKUP: begin
        if (col > COL_W'(LAST_COL)) begin
          // Column check comes first: no row gets allocated.
          res.status = STAT_BAD_COLUMN;
        end else begin
          for (int r = 0; r < ROWS; r++) begin
            if (row < 0 && shadow_taken[r] && shadow_key[r] == key) row = r;
          end
          if (op == OP_INSERT) begin
            if (row < 0) begin
              // Take the lowest free row and wipe it to the empty marker.
              for (int r = 0; r < ROWS; r++) begin
                if (row < 0 && !shadow_taken[r]) row = r;
              end
              if (row >= 0) begin
                shadow_taken[row] = 1'b1;
                shadow_key[row]   = key;
                for (int c = 0; c <= LAST_COL; c++) shadow_cell[row][c] = EMPTY_CELL;
              end
            end
            if (row < 0) res.status = STAT_FULL;
            else shadow_cell[row][col] = val;
          end else if (row < 0 || shadow_cell[row][col][CELL_W-1]) begin
            res.status = STAT_MISS;
          end else begin
            res.found = shadow_cell[row][col][FOUND_W-1:0];
          end
        end
      end
      default: begin
        res.status = STAT_MISS;
      end
    endcase
    return res;
  endfunction

  // Offer one beat, idling first at random, and record its answer once accepted.
  // Valid is only dropped on an idle cycle, so back-to-back beats keep it high.
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [COL_W-1:0] col, input logic [CELL_W-1:0] val);
    @(negedge clk);
    if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < IDLE_PERCENT);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_row_key    <= key;
    in_column     <= col;
    in_cell_value <= val;
    do @(posedge clk); while (!in_ready);
    awaited_results.push_back(table_answer(op, key, col, val));
  endtask

  // Drop valid and hold off until every awaited result has arrived.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Extremes of every field, each opcode, empty markers, bad columns, clear.
  task automatic test_basic_ops();
    send_beat(OP_LOOKUP, 32'h0000_0000, 11'd0, 16'h0000);       // empty table: miss
    send_beat(OP_INSERT, 32'h8000_0000, 11'd0, 16'h7FFF);
    send_beat(OP_LOOKUP, 32'h8000_0000, 11'd0, 16'h0000);       // hit, largest value
    send_beat(OP_INSERT, 32'h7FFF_FFFF, COL_W'(LAST_COL), 16'h0000);
    send_beat(OP_LOOKUP, 32'h7FFF_FFFF, COL_W'(LAST_COL), 16'hFFFF);  // hit, value zero
    send_beat(OP_INSERT, 32'h8000_0000, COL_W'(LAST_COL), 16'h8000);  // most negative stored
    send_beat(OP_LOOKUP, 32'h8000_0000, COL_W'(LAST_COL), 16'h0000);  // negative cell: miss
    send_beat(OP_LOOKUP, 32'h8000_0000, 11'd5, 16'h0000);       // never written: miss
    send_beat(OP_INSERT, 32'hFFFF_FFFF, COL_W'(LAST_COL + 1), 16'h0001); // bad column
    send_beat(OP_LOOKUP, 32'hFFFF_FFFF, 11'd0, 16'h0000);       // no row was made
    send_beat(OP_LOOKUP, 32'h7FFF_FFFF, 11'h7FF, 16'h0000);     // bad column
    send_beat(OP_INSERT, 32'hFFFF_FFFF, 11'd512, 16'hFFFF);     // empty marker itself
    send_beat(OP_LOOKUP, 32'hFFFF_FFFF, 11'd512, 16'h0000);
    send_beat(OP_UNUSED, 32'h7FFF_FFFF, COL_W'(LAST_COL), 16'h1234);  // ignored opcode
    send_beat(OP_LOOKUP, 32'h7FFF_FFFF, COL_W'(LAST_COL), 16'h0000);
    send_beat(OP_CLEAR,  32'h0000_0000, 11'd0, 16'h0000);
    send_beat(OP_LOOKUP, 32'h7FFF_FFFF, COL_W'(LAST_COL), 16'h0000);  // cleared: miss
    send_beat(OP_INSERT, 32'h7FFF_FFFF, 11'd7, 16'h5555);       // reuse a freed row
    send_beat(OP_LOOKUP, 32'h7FFF_FFFF, COL_W'(LAST_COL), 16'h0000);  // old cell wiped
    send_beat(OP_LOOKUP, 32'h7FFF_FFFF, 11'd7, 16'h0000);
    send_beat(OP_INSERT, 32'h7FFF_FFFF, 11'd7, 16'h2AAA);       // overwrite in place
    send_beat(OP_LOOKUP, 32'h7FFF_FFFF, 11'd7, 16'h0000);
    wait_for_results();
  endtask

  // Fill every row, then push past the end of the table.
  task automatic test_full_table();
    logic [KEY_W-1:0] key;
    send_beat(OP_CLEAR, 32'h0, 11'd0, 16'h0);
    for (int i = 0; i < ROWS; i++) begin
      key = {i[7:0], ~i[7:0], 16'($urandom())};
      send_beat(OP_INSERT, key, COL_W'(i), CELL_W'(i * 3));
    end
    send_beat(OP_INSERT, 32'hDEAD_0000, 11'd1, 16'h0042);     // no free row: full
    send_beat(OP_INSERT, 32'hDEAD_0000, COL_W'(LAST_COL + 1), 16'h0); // column checked first
    send_beat(OP_INSERT, key, 11'd9, 16'h0099);               // existing row still writable
    send_beat(OP_LOOKUP, key, 11'd9, 16'h0);
    send_beat(OP_LOOKUP, 32'hDEAD_0000, 11'd1, 16'h0);
    send_beat(OP_CLEAR, 32'h0, 11'd0, 16'h0);
    send_beat(OP_LOOKUP, key, 11'd9, 16'h0);
    send_beat(OP_INSERT, 32'hDEAD_0000, 11'd1, 16'h0042);     // room again
    wait_for_results();
  endtask

  // Hold the result side for a long stretch while beats keep coming.
  task automatic test_backpressure();
    send_beat(OP_INSERT, 32'h0BAD_F00D, 11'd3, 16'h0333);
    wait_for_results();
    hold_request = 1'b1;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 0) send_beat(OP_INSERT, 32'h0BAD_F00D, COL_W'(i), CELL_W'($urandom()));
      else send_beat(OP_LOOKUP, 32'h0BAD_F00D, COL_W'(i - 1), 16'h0);
    end
    wait_for_results();
  endtask

  // Draw a fresh set of keys and columns so the next stretch hits its own rows.
  task automatic refresh_pools();
    foreach (key_pool[k]) key_pool[k] = $urandom();
    col_pool[0] = '0;
    col_pool[1] = COL_W'(LAST_COL);
    for (int c = 2; c < COL_POOL; c++) col_pool[c] = COL_W'($urandom_range(LAST_COL));
  endtask

  // Mostly insert/lookup on a small key set so lookups hit; some noise and clears.
  task automatic test_random_traffic();
    int               pick;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [COL_W-1:0] col;
    logic [CELL_W-1:0] val;
    refresh_pools();
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      calm = (n >= 500 && n < 800);
      pick = $urandom_range(99);
      key  = key_pool[$urandom_range(KEY_POOL - 1)];
      col  = ($urandom_range(99) < 80) ? col_pool[$urandom_range(COL_POOL - 1)]
                                       : COL_W'($urandom_range(LAST_COL));
      val  = ($urandom_range(3) == 0) ? CELL_W'($urandom()) : CELL_W'($urandom_range(32767));
      if (pick < 2) begin
        op = OP_CLEAR;
      end else if (pick < 12) begin
        // Noise: any opcode, any key, any column.
        op  = OP_W'($urandom_range(3));
        key = $urandom();
        col = COL_W'($urandom_range(2047));
        val = CELL_W'($urandom());
      end else if (pick < 50) begin
        op = OP_INSERT;
      end else begin
        op = OP_LOOKUP;
      end
      send_beat(op, key, col, val);
      if (op == OP_CLEAR) refresh_pools();
    end
    calm = 1'b0;
    wait_for_results();
  endtask

  // Receiver: random stalls, a quiet stretch, and one long hold counted here.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Check every result beat against the oldest awaited answer.
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing awaited: status %0d found_value %0d",
               out_status, out_found_value);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d (%s) actual %0d", want.status, want.status.name(),
                 out_status);
          fail_count++;
        end
        if (out_found_value !== want.found) begin
          $error("found_value: expected %0d actual %0d", want.found, out_found_value);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL two_key_lookup_table");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = OP_CLEAR;
    in_row_key    = '0;
    in_column     = '0;
    in_cell_value = '0;
    foreach (shadow_taken[r]) shadow_taken[r] = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_full_table();
    test_backpressure();
    test_random_traffic();

    // Let any stray beat show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS two_key_lookup_table");
    end else begin
      $display("FAIL two_key_lookup_table");
    end
    $finish;
  end

endmodule
